>>> rtl/core/byte_budget_lru_cache_with_pinning_assert.svh
// Assertion macros for the byte-budget LRU cache.
// Depends on nothing; included by the checker module.
`ifndef BYTE_BUDGET_LRU_CACHE_WITH_PINNING_ASSERT_SVH
`define BYTE_BUDGET_LRU_CACHE_WITH_PINNING_ASSERT_SVH

// Clocked property, disabled while reset is low.
`define BLRU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property, checked during reset too.
`define BLRU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/blru_pkg.sv
// Shared types and codes for the byte-budget LRU cache.
// No dependencies; used by blru_cell, the top level and the checker.
package blru_pkg;

    localparam logic [2:0] KIND_INSERT = 3'd0;
    localparam logic [2:0] KIND_TOUCH  = 3'd1;
    localparam logic [2:0] KIND_ERASE  = 3'd2;
    localparam logic [2:0] KIND_LOOKUP = 3'd3;
    localparam logic [2:0] KIND_CLEAR  = 3'd4;
    localparam logic [2:0] KIND_TRIM   = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_TOO_BIG = 2'd2;
    localparam logic [1:0] ST_NO_ROOM = 2'd3;

    localparam logic [2:0] OP_NOP   = 3'd0;
    localparam logic [2:0] OP_WRITE = 3'd1;
    localparam logic [2:0] OP_DROP  = 3'd2;
    localparam logic [2:0] OP_TOUCH = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    localparam int unsigned MAX_EVICT = 32;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] key;
        logic [31:0] bytes;
        logic [63:0] stamp;
        logic        pin;
    } t_cell_cmd;

    typedef struct packed {
        logic        v;
        logic [63:0] stamp;
        logic [31:0] key;
        logic [31:0] bytes;
    } t_cand;

    typedef struct packed {
        logic        valid;
        logic        pinned;
        logic [31:0] key;
        logic [31:0] bytes;
        logic [63:0] stamp;
    } t_cell_view;

endpackage

>>> rtl/core/blru_cell.sv
// One table slot of the LRU cache plus its stage of the victim/sum chain.
// Depends on blru_pkg.
module blru_cell #(
    parameter int unsigned IDX_W  = 5,
    parameter int unsigned MY_IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  blru_pkg::t_cell_cmd i_cmd,
    input  logic                i_sel,
    input  logic [31:0]         i_key,
    input  blru_pkg::t_cand     i_cand,
    input  logic [IDX_W-1:0]    i_cand_idx,
    input  logic [31:0]         i_sum,
    output blru_pkg::t_cand     o_cand,
    output logic [IDX_W-1:0]    o_cand_idx,
    output logic [31:0]         o_sum,
    output logic                o_match,
    output blru_pkg::t_cell_view o_view
);

    logic        r_valid;
    logic        r_pinned;
    logic [31:0] r_key;
    logic [31:0] r_bytes;
    logic [63:0] r_stamp;
    logic        w_elig;
    logic        w_take;

    blru_pkg::t_cand  r_cand;
    logic [IDX_W-1:0] r_cand_idx;
    logic [31:0]      r_sum;

    assign w_elig = r_valid & ~r_pinned;
    assign w_take = w_elig & (~i_cand.v | (r_stamp < i_cand.stamp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                blru_pkg::OP_WRITE: if (i_sel) r_valid <= 1'b1;
                blru_pkg::OP_DROP:  if (i_sel) r_valid <= 1'b0;
                blru_pkg::OP_CLEAR: if (!r_pinned) r_valid <= 1'b0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sel && i_cmd.op == blru_pkg::OP_WRITE) begin
            r_key    <= i_cmd.key;
            r_bytes  <= i_cmd.bytes;
            r_pinned <= i_cmd.pin;
        end
        if (i_sel && (i_cmd.op == blru_pkg::OP_WRITE || i_cmd.op == blru_pkg::OP_TOUCH)) begin
            r_stamp <= i_cmd.stamp;
        end
    end

    // Advance the chain: keep the older candidate, accumulate evictable bytes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand.v <= 1'b0;
        end else begin
            r_cand.v <= i_cand.v | w_take;
        end
        if (w_take) begin
            r_cand.stamp <= r_stamp;
            r_cand.key   <= r_key;
            r_cand.bytes <= r_bytes;
            r_cand_idx   <= IDX_W'(MY_IDX);
        end else begin
            r_cand.stamp <= i_cand.stamp;
            r_cand.key   <= i_cand.key;
            r_cand.bytes <= i_cand.bytes;
            r_cand_idx   <= i_cand_idx;
        end
        r_sum <= i_sum + (w_elig ? r_bytes : 32'd0);
    end

    assign o_cand     = r_cand;
    assign o_cand_idx = r_cand_idx;
    assign o_sum      = r_sum;
    assign o_match    = r_valid & (r_key == i_key);
    assign o_view     = '{valid: r_valid, pinned: r_pinned, key: r_key,
                          bytes: r_bytes, stamp: r_stamp};

endmodule

>>> rtl/core/byte_budget_lru_cache_with_pinning.sv
// Top level of the byte-budget LRU cache with pinned entries.
// Depends on blru_pkg and blru_cell.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one command item: kind,
//   key, size_bytes, pin. Output channel (o_out_valid / i_out_ready) carries
//   result items: one per evicted entry (o_evicted=1), then a final item
//   with o_last=1. Configuration: i_cfg_we writes i_cfg_data as the byte
//   budget; the user must do so only while idle (the block does not check).
// Sequence:
//   Touch, erase, lookup and unknown kinds: accepted in S_IDLE, decoded in
//   S_DEC, which registers the result. Insert without eviction passes S_DEC
//   and then S_FIT, which registers it. Each eviction adds a budget check
//   in S_FIT and a wait in S_SCAN while the chain of cells settles, and a
//   clear also waits in S_SCAN; the chain length sets that wait. One item
//   is worked on at a time; o_in_ready is high only while idle.
// Reset:
//   Synchronous, active low: table empty, resident bytes and stamp counter
//   zero, budget all ones. No clearing pass is needed.
// Stall:
//   A result waits in the output register while i_out_ready is low; the
//   sequencer holds until the register frees, and a new item can be taken
//   while the final result of the previous one still waits.
module byte_budget_lru_cache_with_pinning #(
    parameter int unsigned ENTRIES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_kind,
    input  logic [31:0] i_key,
    input  logic [31:0] i_size_bytes,
    input  logic        i_pin,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic        o_evicted,
    output logic [31:0] o_out_key,
    output logic [31:0] o_out_bytes,
    output logic        o_out_pinned,
    output logic [31:0] o_out_stamp,
    output logic        o_hit,
    output logic [31:0] o_used_total,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data
);

    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW = $clog2(ENTRIES + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_FIT  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;

    logic [2:0]  r_state, n_state;
    logic [2:0]  r_kind;
    logic [31:0] r_key;
    logic [31:0] r_size, n_size;
    logic        r_pin;
    logic [31:0] r_budget;
    logic [31:0] r_res, n_res;
    logic [63:0] r_ctr, n_ctr;
    logic [5:0]  r_k, n_k;
    logic [CW-1:0] r_cnt, n_cnt;
    logic        r_clr, n_clr;

    blru_pkg::t_cell_cmd w_cmd;
    logic [IW-1:0]       w_cmd_idx;

    blru_pkg::t_cand      w_cand [ENTRIES+1];
    logic [IW-1:0]        w_cidx [ENTRIES+1];
    logic [31:0]          w_sum  [ENTRIES+1];
    logic [ENTRIES-1:0]   w_match;
    logic [ENTRIES-1:0]   w_valid;
    blru_pkg::t_cell_view w_view [ENTRIES];

    logic        w_hit;
    logic [IW-1:0] w_hidx;
    logic [31:0] w_hkey, w_hbytes;
    logic [63:0] w_hstamp;
    logic        w_hpin;
    logic        w_free_any;
    logic [IW-1:0] w_free_idx;
    logic        w_can_emit;
    logic        w_over;
    logic        w_need;

    logic        e_emit;
    logic [1:0]  e_status;
    logic        e_evicted, e_pinned, e_hit, e_last;
    logic [31:0] e_key, e_bytes, e_stamp;

    logic        r_ovalid;
    logic [1:0]  r_ostatus;
    logic        r_oevicted, r_opinned, r_ohit, r_olast;
    logic [31:0] r_okey, r_obytes, r_ostamp, r_oused;

    assign w_cand[0] = '{default: '0};
    assign w_cidx[0] = '0;
    assign w_sum[0]  = 32'd0;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            blru_cell #(.IDX_W(IW), .MY_IDX(g)) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_cmd      (w_cmd),
                .i_sel      (w_cmd_idx == IW'(g)),
                .i_key      (r_key),
                .i_cand     (w_cand[g]),
                .i_cand_idx (w_cidx[g]),
                .i_sum      (w_sum[g]),
                .o_cand     (w_cand[g+1]),
                .o_cand_idx (w_cidx[g+1]),
                .o_sum      (w_sum[g+1]),
                .o_match    (w_match[g]),
                .o_view     (w_view[g])
            );
            assign w_valid[g] = w_view[g].valid;
        end
    endgenerate

    // Keys are unique among valid slots, so an AND-OR gather finds the hit.
    always_comb begin
        w_hidx   = '0;
        w_hkey   = '0;
        w_hbytes = '0;
        w_hstamp = '0;
        w_hpin   = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (w_match[i]) begin
                w_hidx   = w_hidx | IW'(i);
                w_hkey   = w_hkey | w_view[i].key;
                w_hbytes = w_hbytes | w_view[i].bytes;
                w_hstamp = w_hstamp | w_view[i].stamp;
                w_hpin   = w_hpin | w_view[i].pinned;
            end
        end
    end
    assign w_hit = |w_match;

    // Lowest free slot.
    always_comb begin
        w_free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!w_valid[i]) w_free_idx = IW'(i);
        end
    end
    assign w_free_any = ~&w_valid;

    assign w_can_emit = ~r_ovalid | i_out_ready;
    assign w_over     = ({1'b0, r_res} + {1'b0, r_size}) > {1'b0, r_budget};
    assign w_need     = w_over | ((r_kind == blru_pkg::KIND_INSERT) & ~w_free_any);
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_size    = r_size;
        n_res     = r_res;
        n_ctr     = r_ctr;
        n_k       = r_k;
        n_cnt     = r_cnt;
        n_clr     = r_clr;
        w_cmd     = '{op: blru_pkg::OP_NOP, key: r_key, bytes: r_size,
                      stamp: r_ctr + 64'd1, pin: r_pin};
        w_cmd_idx = '0;
        e_emit    = 1'b0;
        e_status  = blru_pkg::ST_OK;
        e_evicted = 1'b0;
        e_key     = '0;
        e_bytes   = '0;
        e_pinned  = 1'b0;
        e_stamp   = '0;
        e_hit     = 1'b0;
        e_last    = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DEC;
                    n_size  = i_size_bytes;
                    n_k     = '0;
                    n_clr   = 1'b0;
                end
            end
            S_DEC: begin
                if (w_can_emit) begin
                    case (r_kind)
                        blru_pkg::KIND_INSERT: begin
                            if (w_hit) begin
                                w_cmd.op  = blru_pkg::OP_DROP;
                                w_cmd_idx = w_hidx;
                                n_res     = r_res - w_hbytes;
                            end
                            if (r_size > r_budget) begin
                                e_emit   = 1'b1;
                                e_status = blru_pkg::ST_TOO_BIG;
                                n_state  = S_IDLE;
                            end else begin
                                n_state = S_FIT;
                            end
                        end
                        blru_pkg::KIND_TOUCH: begin
                            e_emit  = 1'b1;
                            n_state = S_IDLE;
                            if (w_hit) begin
                                n_ctr     = r_ctr + 64'd1;
                                w_cmd.op  = blru_pkg::OP_TOUCH;
                                w_cmd_idx = w_hidx;
                            end else begin
                                e_status = blru_pkg::ST_MISS;
                            end
                        end
                        blru_pkg::KIND_ERASE: begin
                            e_emit  = 1'b1;
                            n_state = S_IDLE;
                            if (w_hit) begin
                                w_cmd.op  = blru_pkg::OP_DROP;
                                w_cmd_idx = w_hidx;
                                n_res     = r_res - w_hbytes;
                            end else begin
                                e_status = blru_pkg::ST_MISS;
                            end
                        end
                        blru_pkg::KIND_LOOKUP: begin
                            e_emit  = 1'b1;
                            n_state = S_IDLE;
                            if (w_hit) begin
                                e_key    = w_hkey;
                                e_bytes  = w_hbytes;
                                e_pinned = w_hpin;
                                e_stamp  = w_hstamp[31:0];
                                e_hit    = 1'b1;
                            end else begin
                                e_status = blru_pkg::ST_MISS;
                            end
                        end
                        blru_pkg::KIND_CLEAR: begin
                            n_clr   = 1'b1;
                            n_cnt   = '0;
                            n_state = S_SCAN;
                        end
                        blru_pkg::KIND_TRIM: begin
                            n_size  = '0;
                            n_state = S_FIT;
                        end
                        default: begin
                            e_emit  = 1'b1;
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_FIT: begin
                if (w_can_emit) begin
                    if (w_need) begin
                        if (r_k == 6'(blru_pkg::MAX_EVICT)) begin
                            e_emit   = 1'b1;
                            e_status = blru_pkg::ST_NO_ROOM;
                            n_state  = S_IDLE;
                        end else begin
                            n_cnt   = '0;
                            n_state = S_SCAN;
                        end
                    end else begin
                        e_emit  = 1'b1;
                        n_state = S_IDLE;
                        if (r_kind == blru_pkg::KIND_INSERT) begin
                            n_ctr     = r_ctr + 64'd1;
                            w_cmd.op  = blru_pkg::OP_WRITE;
                            w_cmd_idx = w_free_idx;
                            n_res     = r_res + r_size;
                        end
                    end
                end
            end
            S_SCAN: begin
                // Wait until the chain has settled over every cell.
                if (r_cnt != CW'(ENTRIES)) begin
                    n_cnt = r_cnt + CW'(1);
                end else if (w_can_emit) begin
                    e_emit = 1'b1;
                    if (r_clr) begin
                        w_cmd.op = blru_pkg::OP_CLEAR;
                        n_res    = r_res - w_sum[ENTRIES];
                        n_state  = S_IDLE;
                    end else if (!w_cand[ENTRIES].v) begin
                        e_status = blru_pkg::ST_NO_ROOM;
                        n_state  = S_IDLE;
                    end else begin
                        w_cmd.op  = blru_pkg::OP_DROP;
                        w_cmd_idx = w_cidx[ENTRIES];
                        n_res     = r_res - w_cand[ENTRIES].bytes;
                        e_evicted = 1'b1;
                        e_last    = 1'b0;
                        e_key     = w_cand[ENTRIES].key;
                        e_bytes   = w_cand[ENTRIES].bytes;
                        n_k       = r_k + 6'd1;
                        n_state   = S_FIT;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_budget <= 32'hFFFF_FFFF;
            r_res    <= '0;
            r_ctr    <= '0;
            r_k      <= '0;
            r_cnt    <= '0;
            r_clr    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
            r_ctr   <= n_ctr;
            r_k     <= n_k;
            r_cnt   <= n_cnt;
            r_clr   <= n_clr;
            if (i_cfg_we) r_budget <= i_cfg_data;
            if (e_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers: command latch and output record.
    always_ff @(posedge i_clk) begin
        r_size <= n_size;
        if (r_state == S_IDLE && i_in_valid) begin
            r_kind <= i_kind;
            r_key  <= i_key;
            r_pin  <= i_pin;
        end
        if (e_emit) begin
            r_ostatus  <= e_status;
            r_oevicted <= e_evicted;
            r_okey     <= e_key;
            r_obytes   <= e_bytes;
            r_opinned  <= e_pinned;
            r_ostamp   <= e_stamp;
            r_ohit     <= e_hit;
            r_olast    <= e_last;
            r_oused    <= n_res;
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_status     = r_ostatus;
    assign o_evicted    = r_oevicted;
    assign o_out_key    = r_okey;
    assign o_out_bytes  = r_obytes;
    assign o_out_pinned = r_opinned;
    assign o_out_stamp  = r_ostamp;
    assign o_hit        = r_ohit;
    assign o_used_total = r_oused;
    assign o_last       = r_olast;

endmodule

>>> rtl/core/blru_checker.sv
// Port-level checks for the byte-budget LRU cache, bound to the top level.
// Depends on blru_pkg and byte_budget_lru_cache_with_pinning_assert.svh.
`include "byte_budget_lru_cache_with_pinning_assert.svh"

module blru_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic        o_evicted,
    input logic        o_hit,
    input logic        o_last,
    input logic [31:0] o_out_key
);

    `BLRU_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_key), "output item dropped while stalled")
    `BLRU_ASSERT(a_evict_not_last, i_clk, i_rst_n, o_out_valid && o_evicted |-> !o_last && o_status == blru_pkg::ST_OK && !o_hit, "bad eviction report")
    `BLRU_ASSERT(a_hit_final_ok, i_clk, i_rst_n, o_out_valid && o_hit |-> o_last && o_status == blru_pkg::ST_OK, "bad lookup hit result")
    `BLRU_ASSERT_ALWAYS(a_reset_idle, i_clk, !$past(i_rst_n) |-> !o_out_valid, "output valid after reset")

endmodule

bind byte_budget_lru_cache_with_pinning blru_checker u_blru_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_status    (o_status),
    .o_evicted   (o_evicted),
    .o_hit       (o_hit),
    .o_last      (o_last),
    .o_out_key   (o_out_key)
);

>>> verif/byte_budget_lru_cache_with_pinning_test.sv
// Testbench for the byte-budget LRU cache with pinned entries.
// Depends on blru_pkg and the RTL top level byte_budget_lru_cache_with_pinning.
// A cycle-free predictor feeds a scoreboard class that checks every result item.
module byte_budget_lru_cache_with_pinning_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SLOTS          = 32;
    localparam int unsigned ITEM_GOAL      = 430;
    localparam int unsigned DIRECTED_ITEMS = 130;
    localparam int unsigned CYCLE_CAP      = 4000000;
    localparam int unsigned TAIL_WAIT      = 200;
    localparam logic [2:0]  KIND_BOGUS     = 3'd6;
    localparam logic [2:0]  KIND_BOGUS_TOP = 3'd7;

    typedef struct packed {
        logic [1:0]  status;
        logic        evicted;
        logic [31:0] out_key;
        logic [31:0] out_bytes;
        logic        out_pinned;
        logic [31:0] out_stamp;
        logic        hit;
        logic [31:0] used_total;
        logic        last;
    } t_result;

    int unsigned mismatch_count = 0;

    // Print one line per mismatch and count it.
    task automatic report(input string what);
        $display("[%0t] error: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Shadow cache: the predictor state and the queue of expected results.
    class cache_scoreboard;
        logic [31:0] budget;
        bit          live   [SLOTS];
        logic [31:0] tag    [SLOTS];
        logic [31:0] nbytes [SLOTS];
        logic [63:0] stamp  [SLOTS];
        bit          pinned [SLOTS];
        logic [31:0] resident;
        logic [63:0] use_count;
        t_result     pending[$];
        int          eviction_count;

        function new();
            budget = '1;
            resident = 0;
            use_count = 0;
            eviction_count = 0;
            foreach (live[i]) live[i] = 0;
        endfunction

        function int find_slot(logic [31:0] k);
            for (int i = 0; i < SLOTS; i++)
                if (live[i] && tag[i] == k) return i;
            return -1;
        endfunction

        function void queue_expect(t_result r);
            pending.insert(pending.size(), r);
        endfunction

        function void push_final(logic [1:0] st);
            t_result r;
            r = '0;
            r.status = st;
            r.used_total = resident;
            r.last = 1;
            queue_expect(r);
        endfunction

        // Remove the oldest unpinned entry and queue its report.
        function bit evict_oldest(ref int reported);
            int v;
            t_result r;
            v = -1;
            if (reported >= blru_pkg::MAX_EVICT) return 0;
            for (int i = 0; i < SLOTS; i++)
                if (live[i] && !pinned[i] && (v < 0 || stamp[i] < stamp[v])) v = i;
            if (v < 0) return 0;
            live[v] = 0;
            resident = resident - nbytes[v];
            r = '0;
            r.evicted = 1;
            r.out_key = tag[v];
            r.out_bytes = nbytes[v];
            r.used_total = resident;
            queue_expect(r);
            reported++;
            eviction_count++;
            return 1;
        endfunction

        function bit evict_to_fit(logic [31:0] need, ref int reported);
            logic [32:0] limit;
            limit = {1'b0, budget} - {1'b0, need};
            while ({1'b0, resident} > limit)
                if (!evict_oldest(reported)) return 0;
            return 1;
        endfunction

        function int first_free();
            for (int i = 0; i < SLOTS; i++)
                if (!live[i]) return i;
            return -1;
        endfunction

        // Note one accepted command item and queue what it must produce.
        function void note_item(logic [2:0] kind, logic [31:0] k,
                                logic [31:0] sz, logic pin);
            int s;
            int reported;
            t_result r;
            reported = 0;
            case (kind)
                blru_pkg::KIND_INSERT: begin
                    s = find_slot(k);
                    if (s >= 0) begin
                        live[s] = 0;
                        resident = resident - nbytes[s];
                    end
                    if (sz > budget) begin
                        push_final(blru_pkg::ST_TOO_BIG);
                        return;
                    end
                    if (!evict_to_fit(sz, reported)) begin
                        push_final(blru_pkg::ST_NO_ROOM);
                        return;
                    end
                    s = first_free();
                    if (s < 0) begin
                        if (!evict_oldest(reported)) begin
                            push_final(blru_pkg::ST_NO_ROOM);
                            return;
                        end
                        s = first_free();
                    end
                    use_count++;
                    live[s] = 1;
                    tag[s] = k;
                    nbytes[s] = sz;
                    stamp[s] = use_count;
                    pinned[s] = pin;
                    resident = resident + sz;
                    push_final(blru_pkg::ST_OK);
                end
                blru_pkg::KIND_TOUCH: begin
                    s = find_slot(k);
                    if (s < 0) push_final(blru_pkg::ST_MISS);
                    else begin
                        use_count++;
                        stamp[s] = use_count;
                        push_final(blru_pkg::ST_OK);
                    end
                end
                blru_pkg::KIND_ERASE: begin
                    s = find_slot(k);
                    if (s < 0) push_final(blru_pkg::ST_MISS);
                    else begin
                        live[s] = 0;
                        resident = resident - nbytes[s];
                        push_final(blru_pkg::ST_OK);
                    end
                end
                blru_pkg::KIND_LOOKUP: begin
                    s = find_slot(k);
                    if (s < 0) push_final(blru_pkg::ST_MISS);
                    else begin
                        r = '0;
                        r.out_key = tag[s];
                        r.out_bytes = nbytes[s];
                        r.out_pinned = pinned[s];
                        r.out_stamp = stamp[s][31:0];
                        r.hit = 1;
                        r.used_total = resident;
                        r.last = 1;
                        queue_expect(r);
                    end
                end
                blru_pkg::KIND_CLEAR: begin
                    for (int i = 0; i < SLOTS; i++)
                        if (live[i] && !pinned[i]) begin
                            live[i] = 0;
                            resident = resident - nbytes[i];
                        end
                    push_final(blru_pkg::ST_OK);
                end
                blru_pkg::KIND_TRIM: begin
                    if (!evict_to_fit(0, reported)) push_final(blru_pkg::ST_NO_ROOM);
                    else push_final(blru_pkg::ST_OK);
                end
                default: push_final(blru_pkg::ST_OK);
            endcase
        endfunction

        // Compare one result item against the oldest expectation.
        task check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result item %h", got));
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.evicted !== want.evicted)
                report($sformatf("evicted %0b, want %0b", got.evicted, want.evicted));
            if (got.out_key !== want.out_key)
                report($sformatf("out_key %h, want %h", got.out_key, want.out_key));
            if (got.out_bytes !== want.out_bytes)
                report($sformatf("out_bytes %h, want %h", got.out_bytes, want.out_bytes));
            if (got.out_pinned !== want.out_pinned)
                report($sformatf("out_pinned %0b, want %0b",
                                 got.out_pinned, want.out_pinned));
            if (got.out_stamp !== want.out_stamp)
                report($sformatf("out_stamp %h, want %h", got.out_stamp, want.out_stamp));
            if (got.hit !== want.hit)
                report($sformatf("hit %0b, want %0b", got.hit, want.hit));
            if (got.used_total !== want.used_total)
                report($sformatf("used_total %h, want %h",
                                 got.used_total, want.used_total));
            if (got.last !== want.last)
                report($sformatf("last %0b, want %0b", got.last, want.last));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_kind;
    logic [31:0] i_key;
    logic [31:0] i_size_bytes;
    logic        i_pin;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_status;
    logic        o_evicted;
    logic [31:0] o_out_key;
    logic [31:0] o_out_bytes;
    logic        o_out_pinned;
    logic [31:0] o_out_stamp;
    logic        o_hit;
    logic [31:0] o_used_total;
    logic        o_last;
    logic        i_cfg_we;
    logic [31:0] i_cfg_data;

    byte_budget_lru_cache_with_pinning #(.ENTRIES(SLOTS)) dut (.*);

    cache_scoreboard board = new();

    // Idle odds in percent; the phase sequencer changes them.
    int unsigned send_idle_pct = 22;
    int unsigned recv_idle_pct = 72;
    bit          hold_off = 0;
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;

    // Pool of keys reused so that hits, duplicates and evictions happen often.
    logic [31:0] key_pool[16];

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop: a run that hangs fails.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: sample at the rising edge, change ready at the falling edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_result({o_status, o_evicted, o_out_key, o_out_bytes,
                                o_out_pinned, o_out_stamp, o_hit, o_used_total, o_last});
    end

    always @(negedge i_clk) begin
        if (hold_off) i_out_ready <= 0;
        else i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one item and hold it steady until the block takes it. Valid stays
    // up after the accepting edge until the next call or an explicit drop.
    task automatic send_item(input logic [2:0] kind, input logic [31:0] k,
                             input logic [31:0] sz, input logic pin);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 0;
            @(negedge i_clk);
        end
        i_in_valid <= 1;
        i_kind <= kind;
        i_key <= k;
        i_size_bytes <= sz;
        i_pin <= pin;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_item(kind, k, sz, pin);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Drain every expected result, let the block settle, then write the budget.
    task automatic write_budget(input logic [31:0] value);
        i_in_valid <= 0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (TAIL_WAIT) @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_data <= value;
        board.budget = value;
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    // Mostly pooled keys and modest sizes; sometimes fully random fields.
    task automatic send_random();
        logic [2:0]  kind;
        logic [31:0] k;
        logic [31:0] sz;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 40) kind = blru_pkg::KIND_INSERT;
        else if (pick < 55) kind = blru_pkg::KIND_LOOKUP;
        else if (pick < 67) kind = blru_pkg::KIND_TOUCH;
        else if (pick < 79) kind = blru_pkg::KIND_ERASE;
        else if (pick < 84) kind = blru_pkg::KIND_CLEAR;
        else if (pick < 94) kind = blru_pkg::KIND_TRIM;
        else kind = 3'($urandom_range(7));
        k = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(15)];
        case ($urandom_range(3))
            0: sz = $urandom();
            1: sz = $urandom_range(4096);
            default: sz = $urandom_range(300);
        endcase
        send_item(kind, k, sz, $urandom_range(7) == 0);
    endtask

    initial begin
        i_rst_n = 0;
        i_in_valid = 0;
        i_kind = '0;
        i_key = '0;
        i_size_bytes = '0;
        i_pin = 0;
        i_out_ready = 0;
        i_cfg_we = 0;
        i_cfg_data = '0;
        foreach (key_pool[i]) key_pool[i] = $urandom();
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: field extremes, every kind, too large, no room, ties.
        send_item(blru_pkg::KIND_LOOKUP, 32'h0, 32'h0, 0);
        send_item(blru_pkg::KIND_INSERT, 32'h0, 32'h0, 0);
        send_item(blru_pkg::KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
        send_item(blru_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0, 0);
        send_item(blru_pkg::KIND_INSERT, 32'h1234_5678, 32'h10, 0);
        send_item(blru_pkg::KIND_INSERT, 32'hFFFF_FFFF, 32'h20, 1);
        send_item(blru_pkg::KIND_INSERT, 32'h1234_5678, 32'h30, 0);
        send_item(blru_pkg::KIND_TOUCH, 32'h0, 32'h0, 0);
        send_item(blru_pkg::KIND_TOUCH, 32'hDEAD_BEEF, 32'h0, 0);
        send_item(blru_pkg::KIND_ERASE, 32'hDEAD_BEEF, 32'h0, 0);
        send_item(blru_pkg::KIND_LOOKUP, 32'h0, 32'h0, 0);
        send_item(KIND_BOGUS, 32'hAAAA_AAAA, 32'h5555_5555, 1);
        send_item(KIND_BOGUS_TOP, 32'h5555_5555, 32'hAAAA_AAAA, 0);
        write_budget(32'h40);
        send_item(blru_pkg::KIND_TRIM, 32'h0, 32'h0, 0);
        send_item(blru_pkg::KIND_INSERT, 32'h77, 32'h41, 0);
        send_item(blru_pkg::KIND_INSERT, 32'h78, 32'h40, 0);
        send_item(blru_pkg::KIND_INSERT, 32'h79, 32'h40, 1);
        send_item(blru_pkg::KIND_INSERT, 32'h7A, 32'h01, 0);
        send_item(blru_pkg::KIND_CLEAR, 32'h0, 32'h0, 0);
        send_item(blru_pkg::KIND_ERASE, 32'h79, 32'h0, 0);
        write_budget(32'h0);
        send_item(blru_pkg::KIND_INSERT, 32'h1, 32'h0, 0);
        send_item(blru_pkg::KIND_INSERT, 32'h2, 32'h1, 0);
        // Fill every slot with zero-size entries so a new key forces an eviction.
        write_budget(32'hFFFF_FFFF);
        for (int i = 0; i < SLOTS + 3; i++)
            send_item(blru_pkg::KIND_INSERT, 32'h100 + i, 32'h0, i < 2);
        send_item(blru_pkg::KIND_CLEAR, 32'h0, 32'h0, 0);
        // All slots pinned: the slot check has no victim.
        for (int i = 0; i < SLOTS + 1; i++)
            send_item(blru_pkg::KIND_INSERT, 32'h200 + i, 32'h1, 1);
        send_item(blru_pkg::KIND_INSERT, 32'h300, 32'h1, 0);
        for (int i = 0; i < SLOTS; i++)
            send_item(blru_pkg::KIND_ERASE, 32'h200 + i, 32'h0, 0);

        // Long receiver hold-off: the block fills its output and stalls input.
        fork
            begin
                hold_off = 1;
                repeat (300) @(negedge i_clk);
                hold_off = 0;
            end
            repeat (6) send_random();
        join

        // Random phases under several budgets, the all-ones maximum among them.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 72 : 0;
            recv_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 22 : 0;
            for (int b = 0; b < 4; b++) begin
                case (b)
                    0: write_budget(32'h0000_0800);
                    1: write_budget(32'h0000_0100);
                    2: write_budget(32'hFFFF_FFFF);
                    default: write_budget($urandom_range(8192));
                endcase
                send_item(blru_pkg::KIND_TRIM, 32'h0, 32'h0, 0);
                for (int n = 0; n < (ITEM_GOAL - DIRECTED_ITEMS) / 12 - 1; n++)
                    send_random();
            end
        end

        // Let the last results drain.
        i_in_valid <= 0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (TAIL_WAIT) @(negedge i_clk);
        if (mismatch_count == 0 && board.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
